@@ rtl/spq_pkg.sv @@
// Package for the stable priority queue: entry type, request, status and
// sequencer state codes, and the compare result bundle. No dependencies.

package spq_pkg;

    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  priority_lvl;
        logic [15:0] order;
    } t_entry;

    typedef struct packed {
        logic behind;
        logic match;
    } t_cmp;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_QUERY  = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_REM,
        S_DONE
    } t_state;

endpackage

@@ rtl/spq_slot_mem.sv @@
// Slot storage for the queue: one write port, one read port, registered read.
// Depends on spq_pkg for the entry type.

module spq_slot_mem
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  t_entry                                i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output t_entry                                o_rd_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/spq_cmp.sv @@
// Shared compare unit: orders a held slot against the candidate entry and
// matches ids. Depends on spq_pkg.

module spq_cmp
    import spq_pkg::*;
(
    input  t_entry i_slot,
    input  t_entry i_cand,
    output t_cmp   o_res
);

    always_comb begin
        o_res.behind = (i_slot.priority_lvl < i_cand.priority_lvl) ||
                       ((i_slot.priority_lvl == i_cand.priority_lvl) &&
                        (i_slot.order > i_cand.order));
        o_res.match  = (i_slot.id == i_cand.id);
    end

endmodule

@@ rtl/stable_priority_queue_core.sv @@
// Top level of the stable priority queue: sequencer, slot memory, compare
// unit and result register. Depends on spq_pkg, spq_slot_mem, spq_cmp.
//
//  channel | direction | handshake         | payload
//  request | in        | i_valid / o_stall | i_req_type i_item_id i_item_priority i_item_order
//  result  | out       | o_valid / i_stall | o_status o_entry_count o_head_valid o_head_id
//          |           |                   | o_head_priority o_head_order
//
// One request at a time; o_stall is high from the transfer until the sequencer returns idle.
// Insert: after the transfer, each trailing entry that sorts behind moves down a slot, then the item fills the gap.
// Remove: after the transfer, walk every stored slot from the head, one slot per cycle.
// Query, full insert, empty remove: straight from the transfer to the result step, which loads the result register.
// The single read port of the slot memory sets the one-slot-per-cycle pace.
// Reset empties the queue at once; a stalled result holds the sequencer in its last step.

module stable_priority_queue_core
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_item_id,
    input  logic [7:0]  i_item_priority,
    input  logic [15:0] i_item_order,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [4:0]  o_entry_count,
    output logic        o_head_valid,
    output logic [15:0] o_head_id,
    output logic [7:0]  o_head_priority,
    output logic [15:0] o_head_order
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    t_state        r_state, n_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_pos;
    logic          r_found;
    t_status       r_status;
    t_entry        r_item;
    t_entry        r_head;
    logic          r_out_valid;
    logic [1:0]    r_out_status;
    logic [4:0]    r_out_count;
    logic          r_out_head_valid;
    t_entry        r_out_head;

    logic [CW-1:0] cnt_m1, pos_m1, pos_m2, pos_p1;
    logic          in_xfer, out_free, ins_done, rem_last;
    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    t_entry        wr_data, rd_data;
    t_cmp          cmp;

    spq_slot_mem #(.DEPTH(DEPTH)) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    spq_cmp u_cmp (
        .i_slot (rd_data),
        .i_cand (r_item),
        .o_res  (cmp)
    );

    assign cnt_m1   = r_count - CW'(1);
    assign pos_m1   = r_pos - CW'(1);
    assign pos_m2   = r_pos - CW'(2);
    assign pos_p1   = r_pos + CW'(1);
    assign in_xfer  = i_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_stall;
    assign ins_done = (r_pos == '0) || !cmp.behind;
    assign rem_last = (r_pos == cnt_m1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_req_type)
                        REQ_INSERT: n_state = (r_count >= FULL_COUNT) ? S_DONE : S_INS;
                        REQ_REMOVE: n_state = (r_count == '0) ? S_DONE : S_REM;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_INS: begin
                if (ins_done) begin
                    n_state = S_DONE;
                end
            end
            S_REM: begin
                if (rem_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = r_item;
        case (r_state)
            S_IDLE: begin
                rd_addr = (i_req_type == REQ_INSERT) ? cnt_m1[AW-1:0] : '0;
            end
            S_INS: begin
                rd_addr = pos_m2[AW-1:0];
                wr_en   = 1'b1;
                wr_addr = r_pos[AW-1:0];
                wr_data = ins_done ? r_item : rd_data;
            end
            S_REM: begin
                rd_addr = pos_p1[AW-1:0];
                wr_en   = r_found;
                wr_addr = pos_m1[AW-1:0];
                wr_data = rd_data;
            end
            default: begin
                rd_addr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_INS) && ins_done) begin
                r_count <= r_count + CW'(1);
            end
            if ((r_state == S_REM) && rem_last && (r_found || cmp.match)) begin
                r_count <= cnt_m1;
            end
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item   <= '{id: i_item_id, priority_lvl: i_item_priority, order: i_item_order};
            r_found  <= 1'b0;
            r_pos    <= (i_req_type == REQ_INSERT) ? r_count : '0;
            if ((i_req_type == REQ_INSERT) && (r_count >= FULL_COUNT)) begin
                r_status <= ST_FULL;
            end else if ((i_req_type == REQ_REMOVE) && (r_count == '0)) begin
                r_status <= ST_NOT_FOUND;
            end else begin
                r_status <= ST_OK;
            end
        end
        if ((r_state == S_INS) && !ins_done) begin
            r_pos <= pos_m1;
        end
        if (r_state == S_REM) begin
            if (cmp.match) begin
                r_found <= 1'b1;
            end
            if (!rem_last) begin
                r_pos <= pos_p1;
            end else if (!(r_found || cmp.match)) begin
                r_status <= ST_NOT_FOUND;
            end
        end
        if (wr_en && (wr_addr == '0)) begin
            r_head <= wr_data;
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out_status     <= r_status;
            r_out_count      <= 5'(r_count);
            r_out_head_valid <= (r_count != '0);
            r_out_head       <= (r_count != '0) ? r_head : '0;
        end
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_status        = r_out_status;
    assign o_entry_count   = r_out_count;
    assign o_head_valid    = r_out_head_valid;
    assign o_head_id       = r_out_head.id;
    assign o_head_priority = r_out_head.priority_lvl;
    assign o_head_order    = r_out_head.order;

endmodule

@@ rtl/spq_check.sv @@
// Port-level checker for the stable priority queue and its bind to the top.
// Depends on spq_pkg and stable_priority_queue_core.

module spq_check
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_status,
    input logic [4:0]  o_entry_count,
    input logic        o_head_valid,
    input logic [15:0] o_head_id,
    input logic [7:0]  o_head_priority,
    input logic [15:0] o_head_order
);

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request transfer did not hold off the next request");

    a_empty_head_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_head_valid) |->
        ((o_head_id == '0) && (o_head_priority == '0) && (o_head_order == '0)))
        else $error("empty queue shows a nonzero head");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_FULL)) |->
        ((o_entry_count == 5'(DEPTH)) && o_head_valid))
        else $error("full status with a count below depth");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
        (o_valid && $stable(o_status) && $stable(o_entry_count) && $stable(o_head_id)))
        else $error("stalled result changed");

endmodule

bind stable_priority_queue_core spq_check #(.DEPTH(DEPTH)) u_spq_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_status        (o_status),
    .o_entry_count   (o_entry_count),
    .o_head_valid    (o_head_valid),
    .o_head_id       (o_head_id),
    .o_head_priority (o_head_priority),
    .o_head_order    (o_head_order)
);
